// ===== sv/lap_pkg.sv =====
// ---------------------------------------------------------------------------
// lap_pkg
// Shared widths and constants for the look-at quaternion pipeline.
// ---------------------------------------------------------------------------
package lap_pkg;

    localparam int ISQ_ROOT_W = 32;
    localparam int ISQ_IN_W   = 2 * ISQ_ROOT_W;

    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

endpackage

// ===== sv/lap_isqrt.sv =====
// ---------------------------------------------------------------------------
// lap_isqrt
// Pipelined floor square root, one root bit per stage, with sideband tag.
// ---------------------------------------------------------------------------
module lap_isqrt import lap_pkg::*; #(
    parameter int TAG_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [ISQ_IN_W-1:0]   i_n,
    input  logic [TAG_W-1:0]      i_tag,
    output logic                  o_valid,
    output logic [ISQ_ROOT_W-1:0] o_root,
    output logic [TAG_W-1:0]      o_tag
);

    localparam int NS    = ISQ_ROOT_W;
    localparam int REM_W = ISQ_ROOT_W + 3;

    logic [REM_W-1:0]      w_rem  [0:NS];
    logic [ISQ_ROOT_W-1:0] w_root [0:NS];
    logic [ISQ_IN_W-1:0]   w_n    [0:NS];
    logic [TAG_W-1:0]      w_tag  [0:NS];
    logic                  w_v    [0:NS];

    logic [REM_W-1:0]      r_rem  [0:NS-1];
    logic [ISQ_ROOT_W-1:0] r_root [0:NS-1];
    logic [ISQ_IN_W-1:0]   r_n    [0:NS-1];
    logic [TAG_W-1:0]      r_tag  [0:NS-1];
    logic                  r_v    [0:NS-1];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_n[0]    = i_n;
    assign w_tag[0]  = i_tag;
    assign w_v[0]    = i_valid;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [REM_W-1:0]      cur;
        logic [REM_W-1:0]      trial;
        logic [REM_W-1:0]      n_rem;
        logic [ISQ_ROOT_W-1:0] n_root;

        always_comb begin
            cur   = {w_rem[s][REM_W-3:0], w_n[s][ISQ_IN_W-1 -: 2]};
            trial = REM_W'({w_root[s], 2'b01});
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {w_root[s][ISQ_ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {w_root[s][ISQ_ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_n[s]    <= {w_n[s][ISQ_IN_W-3:0], 2'b00};
                r_tag[s]  <= w_tag[s];
            end
        end

        assign w_rem[s+1]  = r_rem[s];
        assign w_root[s+1] = r_root[s];
        assign w_n[s+1]    = r_n[s];
        assign w_tag[s+1]  = r_tag[s];
        assign w_v[s+1]    = r_v[s];
    end

    assign o_valid = w_v[NS];
    assign o_root  = w_root[NS];
    assign o_tag   = w_tag[NS];

endmodule

// ===== sv/lap_div.sv =====
// ---------------------------------------------------------------------------
// lap_div
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
// ---------------------------------------------------------------------------
module lap_div import lap_pkg::*; #(
    parameter int NW    = 62,
    parameter int DW    = 32,
    parameter int QW    = 31,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NW-1:0]    i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [DW:0]      w_rem [0:QW];
    logic [QW-1:0]    w_low [0:QW];
    logic [QW-1:0]    w_q   [0:QW];
    logic [DW-1:0]    w_den [0:QW];
    logic [TAG_W-1:0] w_tag [0:QW];
    logic             w_v   [0:QW];

    logic [DW:0]      r_rem [0:QW-1];
    logic [QW-1:0]    r_low [0:QW-1];
    logic [QW-1:0]    r_q   [0:QW-1];
    logic [DW-1:0]    r_den [0:QW-1];
    logic [TAG_W-1:0] r_tag [0:QW-1];
    logic             r_v   [0:QW-1];

    assign w_rem[0] = (DW+1)'(i_num[NW-1:QW]);
    assign w_low[0] = i_num[QW-1:0];
    assign w_q[0]   = '0;
    assign w_den[0] = i_den;
    assign w_tag[0] = i_tag;
    assign w_v[0]   = i_valid;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW:0]   cur;
        logic [DW:0]   n_rem;
        logic [QW-1:0] n_q;

        always_comb begin
            cur = {w_rem[s][DW-1:0], w_low[s][QW-1]};
            if (cur >= {1'b0, w_den[s]}) begin
                n_rem = cur - {1'b0, w_den[s]};
                n_q   = {w_q[s][QW-2:0], 1'b1};
            end else begin
                n_rem = cur;
                n_q   = {w_q[s][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_low[s] <= {w_low[s][QW-2:0], 1'b0};
                r_q[s]   <= n_q;
                r_den[s] <= w_den[s];
                r_tag[s] <= w_tag[s];
            end
        end

        assign w_rem[s+1] = r_rem[s];
        assign w_low[s+1] = r_low[s];
        assign w_q[s+1]   = r_q[s];
        assign w_den[s+1] = r_den[s];
        assign w_tag[s+1] = r_tag[s];
        assign w_v[s+1]   = r_v[s];
    end

    assign o_valid = w_v[QW];
    assign o_quo   = w_q[QW];
    assign o_tag   = w_tag[QW];

endmodule

// ===== sv/look_at_quaternion.sv =====
// ---------------------------------------------------------------------------
// look_at_quaternion
// Look-at rotation quaternion from eye and target points.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries target and eye, signed Q16.16
//   in the low COORD_WIDTH bits of each port. Output channel (o_valid /
//   i_ready) carries quat x, y, z, w in Q2.30 and the degenerate flag.
//   One result per input, in order.
//   Throughput: one transfer per cycle unless the output stalls. The two
//   square root banks take 32 stages each, the two divider banks 31 and 33
//   stages, and normalize, multiply and select logic adds 14 stages.
//   The whole pipeline advances on one enable: when the output register holds
//   a result the receiver has not taken, every stage holds and o_ready drops;
//   nothing is lost or repeated.
//   Reset (synchronous, active low) clears all valid bits; the pipeline is
//   empty and ready in the next cycle. Degenerate inputs (target equal to eye,
//   or direction parallel to world up) return the identity quaternion.
// ---------------------------------------------------------------------------
module look_at_quaternion import lap_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_quat_x,
    output logic signed [31:0] o_quat_y,
    output logic signed [31:0] o_quat_z,
    output logic signed [31:0] o_quat_w,
    output logic               o_degenerate
);

    localparam int RW    = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
    localparam int AW    = COORD_WIDTH + 1;
    localparam int MSB_W = $clog2(AW);

    function automatic logic [31:0] sat_part(input logic signed [34:0] x);
        if (x > 35'(ONE_Q30)) begin
            return 32'(ONE_Q30);
        end else if (x < -35'(ONE_Q30)) begin
            return 32'(-ONE_Q30);
        end else begin
            return x[31:0];
        end
    endfunction

    logic en;
    logic r_out_v;

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;

    // S1: differences and magnitudes
    logic signed [COORD_WIDTH-1:0] tc [3];
    logic signed [COORD_WIDTH-1:0] ec [3];
    logic signed [AW-1:0]          dd [3];
    logic [AW-1:0] r1_a [3];
    logic          r1_s [3];
    logic          r1_v;

    always_comb begin
        tc[0] = $signed(COORD_WIDTH'(RW'($unsigned(i_target_x))));
        tc[1] = $signed(COORD_WIDTH'(RW'($unsigned(i_target_y))));
        tc[2] = $signed(COORD_WIDTH'(RW'($unsigned(i_target_z))));
        ec[0] = $signed(COORD_WIDTH'(RW'($unsigned(i_eye_x))));
        ec[1] = $signed(COORD_WIDTH'(RW'($unsigned(i_eye_y))));
        ec[2] = $signed(COORD_WIDTH'(RW'($unsigned(i_eye_z))));
        for (int c = 0; c < 3; c++) begin
            dd[c] = AW'(tc[c]) - AW'(ec[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r1_s[c] <= dd[c][AW-1];
                r1_a[c] <= dd[c][AW-1] ? AW'(-dd[c]) : AW'(dd[c]);
            end
        end
    end

    // S2: leading one of the largest magnitude
    logic [AW-1:0]    mx;
    logic [MSB_W-1:0] msb;
    logic [AW-1:0]    r2_a [3];
    logic             r2_s [3];
    logic [MSB_W-1:0] r2_msb;
    logic             r2_zero;
    logic             r2_v;

    always_comb begin
        mx = r1_a[0];
        if (r1_a[1] > mx) mx = r1_a[1];
        if (r1_a[2] > mx) mx = r1_a[2];
        msb = '0;
        for (int b = 0; b < AW; b++) begin
            if (mx[b]) msb = MSB_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a    <= r1_a;
            r2_s    <= r1_s;
            r2_msb  <= msb;
            r2_zero <= (mx == '0);
        end
    end

    // S3: shared shift that puts the largest magnitude into [2^30, 2^31)
    logic [30:0] an [3];
    logic [AW-1:0] rsh [3];
    logic [30:0] r3_a [3];
    logic        r3_s [3];
    logic        r3_deg;
    logic        r3_v;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rsh[c] = r2_a[c] >> (r2_msb - MSB_W'(30));
            if (r2_msb >= MSB_W'(30)) begin
                an[c] = rsh[c][30:0];
            end else begin
                an[c] = 31'(r2_a[c]) << (MSB_W'(30) - r2_msb);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_a   <= an;
            r3_s   <= r2_s;
            r3_deg <= r2_zero || (an[0] == '0 && an[2] == '0);
        end
    end

    // S4: squares, leading one of the horizontal pair
    logic [4:0]  msb2;
    logic [30:0] hor;
    logic [61:0] r4_sq [3];
    logic [4:0]  r4_msb2;
    logic [30:0] r4_a [3];
    logic        r4_s [3];
    logic        r4_deg;
    logic        r4_v;

    always_comb begin
        hor  = r3_a[0] | r3_a[2];
        msb2 = '0;
        for (int b = 0; b < 31; b++) begin
            if (hor[b]) msb2 = 5'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r4_sq[c] <= 62'(r3_a[c]) * 62'(r3_a[c]);
            end
            r4_msb2 <= msb2;
            r4_a    <= r3_a;
            r4_s    <= r3_s;
            r4_deg  <= r3_deg;
        end
    end

    // S5: square sums, horizontal pair shift
    logic [63:0] r5_slen;
    logic [63:0] r5_shh;
    logic [30:0] r5_px;
    logic [30:0] r5_pz;
    logic [30:0] r5_a [3];
    logic        r5_s [3];
    logic        r5_deg;
    logic        r5_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_slen <= 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]);
            r5_shh  <= 64'(r4_sq[0]) + 64'(r4_sq[2]);
            r5_px   <= r4_a[0] << (5'd30 - r4_msb2);
            r5_pz   <= r4_a[2] << (5'd30 - r4_msb2);
            r5_a    <= r4_a;
            r5_s    <= r4_s;
            r5_deg  <= r4_deg;
        end
    end

    // S6: horizontal squares
    logic [61:0] r6_px2;
    logic [61:0] r6_pz2;
    logic [63:0] r6_slen;
    logic [63:0] r6_shh;
    logic [30:0] r6_px;
    logic [30:0] r6_pz;
    logic [30:0] r6_a [3];
    logic        r6_s [3];
    logic        r6_deg;
    logic        r6_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_px2  <= 62'(r5_px) * 62'(r5_px);
            r6_pz2  <= 62'(r5_pz) * 62'(r5_pz);
            r6_slen <= r5_slen;
            r6_shh  <= r5_shh;
            r6_px   <= r5_px;
            r6_pz   <= r5_pz;
            r6_a    <= r5_a;
            r6_s    <= r5_s;
            r6_deg  <= r5_deg;
        end
    end

    // S7: horizontal square sum
    logic [63:0] r7_sh;
    logic [63:0] r7_slen;
    logic [63:0] r7_shh;
    logic [30:0] r7_px;
    logic [30:0] r7_pz;
    logic [30:0] r7_a [3];
    logic        r7_s [3];
    logic        r7_deg;
    logic        r7_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sh   <= 64'(r6_px2) + 64'(r6_pz2);
            r7_slen <= r6_slen;
            r7_shh  <= r6_shh;
            r7_px   <= r6_px;
            r7_pz   <= r6_pz;
            r7_a    <= r6_a;
            r7_s    <= r6_s;
            r7_deg  <= r6_deg;
        end
    end

    // square roots: len, hh, h
    logic [ISQ_ROOT_W-1:0] len_root;
    logic [ISQ_ROOT_W-1:0] hh_root;
    logic [ISQ_ROOT_W-1:0] h_root;
    logic [3:0]            sq_tag_l;
    logic [92:0]           sq_tag_a;
    logic [61:0]           sq_tag_p;
    logic                  sq_v_l;
    logic                  sq_v_a;
    logic                  sq_v_p;

    lap_isqrt #(.TAG_W(4)) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_n     (r7_slen),
        .i_tag   ({r7_deg, r7_s[0], r7_s[1], r7_s[2]}),
        .o_valid (sq_v_l),
        .o_root  (len_root),
        .o_tag   (sq_tag_l)
    );

    lap_isqrt #(.TAG_W(93)) u_sqrt_hh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_n     (r7_shh),
        .i_tag   ({r7_a[0], r7_a[1], r7_a[2]}),
        .o_valid (sq_v_a),
        .o_root  (hh_root),
        .o_tag   (sq_tag_a)
    );

    lap_isqrt #(.TAG_W(62)) u_sqrt_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_n     (r7_sh),
        .i_tag   ({r7_px, r7_pz}),
        .o_valid (sq_v_p),
        .o_root  (h_root),
        .o_tag   (sq_tag_p)
    );

    // S8: dividend setup for the axis divisions
    logic [61:0] r8_n [6];
    logic [31:0] r8_len;
    logic [31:0] r8_h;
    logic        r8_deg;
    logic        r8_s [3];
    logic        r8_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_n[0] <= (62'(sq_tag_a[92:62]) << 30) + 62'(len_root >> 1);
            r8_n[1] <= (62'(sq_tag_a[61:31]) << 30) + 62'(len_root >> 1);
            r8_n[2] <= (62'(sq_tag_a[30:0])  << 30) + 62'(len_root >> 1);
            r8_n[3] <= (62'(hh_root)         << 30) + 62'(len_root >> 1);
            r8_n[4] <= (62'(sq_tag_p[30:0])  << 30) + 62'(h_root >> 1);
            r8_n[5] <= (62'(sq_tag_p[61:31]) << 30) + 62'(h_root >> 1);
            r8_len  <= len_root;
            r8_h    <= h_root;
            r8_deg  <= sq_tag_l[3];
            r8_s[0] <= sq_tag_l[2];
            r8_s[1] <= sq_tag_l[1];
            r8_s[2] <= sq_tag_l[0];
        end
    end

    // axis divisions: zx, zy, zz, yy, xx, xz
    logic [30:0] dq [6];
    logic        dv [6];
    logic [1:0]  dt_zx;
    logic        dt_zy;
    logic        dt_zz;
    logic        dt_yy;
    logic        dt_xx;
    logic        dt_xz;

    lap_div #(.NW(62), .DW(32), .QW(31), .TAG_W(2)) u_div_zx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r8_v),
        .i_num(r8_n[0]), .i_den(r8_len), .i_tag({r8_deg, r8_s[0]}),
        .o_valid(dv[0]), .o_quo(dq[0]), .o_tag(dt_zx)
    );

    lap_div #(.NW(62), .DW(32), .QW(31), .TAG_W(1)) u_div_zy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r8_v),
        .i_num(r8_n[1]), .i_den(r8_len), .i_tag(r8_s[1]),
        .o_valid(dv[1]), .o_quo(dq[1]), .o_tag(dt_zy)
    );

    lap_div #(.NW(62), .DW(32), .QW(31), .TAG_W(1)) u_div_zz (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r8_v),
        .i_num(r8_n[2]), .i_den(r8_len), .i_tag(r8_s[2]),
        .o_valid(dv[2]), .o_quo(dq[2]), .o_tag(dt_zz)
    );

    lap_div #(.NW(62), .DW(32), .QW(31), .TAG_W(1)) u_div_yy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r8_v),
        .i_num(r8_n[3]), .i_den(r8_len), .i_tag(r8_v),
        .o_valid(dv[3]), .o_quo(dq[3]), .o_tag(dt_yy)
    );

    lap_div #(.NW(62), .DW(32), .QW(31), .TAG_W(1)) u_div_xx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r8_v),
        .i_num(r8_n[4]), .i_den(r8_h), .i_tag(r8_s[2]),
        .o_valid(dv[4]), .o_quo(dq[4]), .o_tag(dt_xx)
    );

    lap_div #(.NW(62), .DW(32), .QW(31), .TAG_W(1)) u_div_xz (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r8_v),
        .i_num(r8_n[5]), .i_den(r8_h), .i_tag(r8_s[0]),
        .o_valid(dv[5]), .o_quo(dq[5]), .o_tag(dt_xz)
    );

    // S9: signed matrix entries
    logic signed [31:0] r9_zx, r9_zy, r9_zz, r9_yy, r9_xx, r9_xz;
    logic               r9_deg;
    logic               r9_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_zx  <= dt_zx[0] ? -$signed({1'b0, dq[0]}) : $signed({1'b0, dq[0]});
            r9_zy  <= dt_zy    ? -$signed({1'b0, dq[1]}) : $signed({1'b0, dq[1]});
            r9_zz  <= dt_zz    ? -$signed({1'b0, dq[2]}) : $signed({1'b0, dq[2]});
            r9_yy  <= $signed({1'b0, dq[3]});
            r9_xx  <= dt_xx    ? -$signed({1'b0, dq[4]}) : $signed({1'b0, dq[4]});
            r9_xz  <= dt_xz    ? $signed({1'b0, dq[5]}) : -$signed({1'b0, dq[5]});
            r9_deg <= dt_zx[1];
        end
    end

    // S10: products and trace terms
    logic [30:0] m_zy, m_xz, m_xx;
    logic [61:0] r10_pyx, r10_pyz;
    logic        r10_nyx, r10_nyz;
    logic signed [33:0] r10_e [4];
    logic signed [31:0] r10_zx, r10_zy, r10_xz;
    logic        r10_deg;
    logic        r10_v;

    always_comb begin
        m_zy = r9_zy[31] ? 31'(-r9_zy) : 31'(r9_zy);
        m_xz = r9_xz[31] ? 31'(-r9_xz) : 31'(r9_xz);
        m_xx = r9_xx[31] ? 31'(-r9_xx) : 31'(r9_xx);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_pyx  <= 62'(m_zy) * 62'(m_xz);
            r10_pyz  <= 62'(m_zy) * 62'(m_xx);
            r10_nyx  <= r9_zy[31] != r9_xz[31];
            r10_nyz  <= r9_zy[31] == r9_xx[31];
            r10_e[0] <= 34'(r9_xx) - 34'(r9_yy) - 34'(r9_zz) + ONE_Q30;
            r10_e[1] <= -34'(r9_xx) + 34'(r9_yy) - 34'(r9_zz) + ONE_Q30;
            r10_e[2] <= -34'(r9_xx) - 34'(r9_yy) + 34'(r9_zz) + ONE_Q30;
            r10_e[3] <= 34'(r9_xx) + 34'(r9_yy) + 34'(r9_zz) + ONE_Q30;
            r10_zx   <= r9_zx;
            r10_zy   <= r9_zy;
            r10_xz   <= r9_xz;
            r10_deg  <= r9_deg;
        end
    end

    // S11: rounded products, largest trace term
    logic [31:0] ryx, ryz;
    logic [1:0]  big;
    logic signed [33:0] r11_yx, r11_yz;
    logic signed [33:0] r11_ebig;
    logic [1:0]  r11_big;
    logic signed [31:0] r11_zx, r11_zy, r11_xz;
    logic        r11_deg;
    logic        r11_v;

    always_comb begin
        ryx = 32'((r10_pyx + 62'd536870912) >> 30);
        ryz = 32'((r10_pyz + 62'd536870912) >> 30);
        big = 2'd0;
        if (r10_e[1] > r10_e[big]) big = 2'd1;
        if (r10_e[2] > r10_e[big]) big = 2'd2;
        if (r10_e[3] > r10_e[big]) big = 2'd3;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_yx   <= r10_nyx ? -$signed({2'b00, ryx}) : $signed({2'b00, ryx});
            r11_yz   <= r10_nyz ? -$signed({2'b00, ryz}) : $signed({2'b00, ryz});
            r11_ebig <= r10_e[big];
            r11_big  <= big;
            r11_zx   <= r10_zx;
            r11_zy   <= r10_zy;
            r11_xz   <= r10_xz;
            r11_deg  <= r10_deg;
        end
    end

    // S12: numerators of the other three parts
    logic signed [33:0] s_zxp, s_zxm, s_yzp, s_yzm;
    logic signed [33:0] na, nb, nc;
    logic [63:0] r12_e;
    logic signed [33:0] r12_na, r12_nb, r12_nc;
    logic [1:0]  r12_big;
    logic        r12_deg;
    logic        r12_v;

    always_comb begin
        s_zxp = 34'(r11_zx) + 34'(r11_xz);
        s_zxm = 34'(r11_zx) - 34'(r11_xz);
        s_yzp = r11_yz + 34'(r11_zy);
        s_yzm = r11_yz - 34'(r11_zy);
        unique case (r11_big)
            2'd0: begin
                na = r11_yx;  nb = s_zxp; nc = s_yzm;
            end
            2'd1: begin
                na = r11_yx;  nb = s_yzp; nc = s_zxm;
            end
            2'd2: begin
                na = s_zxp;   nb = s_yzp; nc = -r11_yx;
            end
            default: begin
                na = s_yzm;   nb = s_zxm; nc = -r11_yx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_e   <= 64'($unsigned(r11_ebig[32:0])) << 28;
            r12_na  <= na;
            r12_nb  <= nb;
            r12_nc  <= nc;
            r12_big <= r11_big;
            r12_deg <= r11_deg;
        end
    end

    logic [ISQ_ROOT_W-1:0] v_root;
    logic [104:0]          vq_tag;
    logic                  vq_v;

    lap_isqrt #(.TAG_W(105)) u_sqrt_part (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r12_v),
        .i_n     (r12_e),
        .i_tag   ({r12_deg, r12_big, r12_na, r12_nb, r12_nc}),
        .o_valid (vq_v),
        .o_root  (v_root),
        .o_tag   (vq_tag)
    );

    // S13: dividend setup for the part divisions
    logic [31:0] vfix;
    logic signed [33:0] ta, tb, tc3;
    logic [61:0] r13_n [3];
    logic [31:0] r13_vd;
    logic        r13_sa, r13_sb, r13_sc;
    logic [1:0]  r13_big;
    logic        r13_deg;
    logic        r13_v;

    always_comb begin
        vfix = (v_root == '0) ? 32'd1 : v_root;
        ta   = vq_tag[101:68];
        tb   = vq_tag[67:34];
        tc3  = vq_tag[33:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_n[0] <= (62'(ta[33]  ? -ta  : ta)  << 28) + 62'(vfix >> 1);
            r13_n[1] <= (62'(tb[33]  ? -tb  : tb)  << 28) + 62'(vfix >> 1);
            r13_n[2] <= (62'(tc3[33] ? -tc3 : tc3) << 28) + 62'(vfix >> 1);
            r13_sa   <= ta[33];
            r13_sb   <= tb[33];
            r13_sc   <= tc3[33];
            r13_vd   <= vfix;
            r13_big  <= vq_tag[103:102];
            r13_deg  <= vq_tag[104];
        end
    end

    logic [32:0] pq [3];
    logic        pv [3];
    logic [3:0]  pt_a;
    logic [32:0] pt_b;
    logic        pt_c;

    lap_div #(.NW(62), .DW(32), .QW(33), .TAG_W(4)) u_div_pa (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r13_v),
        .i_num(r13_n[0]), .i_den(r13_vd), .i_tag({r13_deg, r13_big, r13_sa}),
        .o_valid(pv[0]), .o_quo(pq[0]), .o_tag(pt_a)
    );

    lap_div #(.NW(62), .DW(32), .QW(33), .TAG_W(33)) u_div_pb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r13_v),
        .i_num(r13_n[1]), .i_den(r13_vd), .i_tag({r13_sb, r13_vd}),
        .o_valid(pv[1]), .o_quo(pq[1]), .o_tag(pt_b)
    );

    lap_div #(.NW(62), .DW(32), .QW(33), .TAG_W(1)) u_div_pc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r13_v),
        .i_num(r13_n[2]), .i_den(r13_vd), .i_tag(r13_sc),
        .o_valid(pv[2]), .o_quo(pq[2]), .o_tag(pt_c)
    );

    // S14: output register
    logic signed [34:0] qa, qb, qc, qv;
    logic [31:0] px_o, py_o, pz_o, pw_o;
    logic [31:0] r_qx, r_qy, r_qz, r_qw;
    logic        r_deg;

    always_comb begin
        qa = pt_a[0] ? -$signed({2'b00, pq[0]}) : $signed({2'b00, pq[0]});
        qb = pt_b[32] ? -$signed({2'b00, pq[1]}) : $signed({2'b00, pq[1]});
        qc = pt_c ? -$signed({2'b00, pq[2]}) : $signed({2'b00, pq[2]});
        qv = $signed({3'b000, pt_b[31:0]});
        unique case (pt_a[2:1])
            2'd0: begin
                px_o = sat_part(qv); py_o = sat_part(qa);
                pz_o = sat_part(qb); pw_o = sat_part(qc);
            end
            2'd1: begin
                px_o = sat_part(qa); py_o = sat_part(qv);
                pz_o = sat_part(qb); pw_o = sat_part(qc);
            end
            2'd2: begin
                px_o = sat_part(qa); py_o = sat_part(qb);
                pz_o = sat_part(qv); pw_o = sat_part(qc);
            end
            default: begin
                px_o = sat_part(qa); py_o = sat_part(qb);
                pz_o = sat_part(qc); pw_o = sat_part(qv);
            end
        endcase
        if (pt_a[3]) begin
            px_o = '0;
            py_o = '0;
            pz_o = '0;
            pw_o = 32'(ONE_Q30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qx  <= px_o;
            r_qy  <= py_o;
            r_qz  <= pz_o;
            r_qw  <= pw_o;
            r_deg <= pt_a[3];
        end
    end

    // valid chain for the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r10_v   <= 1'b0;
            r11_v   <= 1'b0;
            r12_v   <= 1'b0;
            r13_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= sq_v_l & sq_v_a & sq_v_p;
            r9_v    <= dv[0] & dv[1] & dv[2] & dv[3] & dv[4] & dv[5] & dt_yy;
            r10_v   <= r9_v;
            r11_v   <= r10_v;
            r12_v   <= r11_v;
            r13_v   <= vq_v;
            r_out_v <= pv[0] & pv[1] & pv[2];
        end
    end

    assign o_valid      = r_out_v;
    assign o_quat_x     = r_qx;
    assign o_quat_y     = r_qy;
    assign o_quat_z     = r_qz;
    assign o_quat_w     = r_qw;
    assign o_degenerate = r_deg;

endmodule
